FILE: rtl/lsfe_pkg.sv
package lsfe_pkg;

    localparam int MAX_ORDER = 31;
    localparam int K_W       = $clog2(MAX_ORDER + 1);
    localparam int ODD_W     = K_W + 1;
    localparam int HO_W      = 5;
    localparam int ORD_W     = 5;

    localparam int X_W       = 32;
    localparam int FRAC      = 30;
    localparam int OUT_W     = 32;
    localparam int OUT_FRAC  = 26;

    localparam int P_W       = 34;
    localparam int T_W       = ODD_W + 1 + P_W;
    localparam int NUM_W     = T_W + 1;
    localparam int MA_W      = P_W + 1;
    localparam int MB_W      = X_W + 1;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int SCALE_W   = 32;

    localparam int DIGIT_W   = 8;
    localparam int DIV_W     = 48;
    localparam int DIV_STEPS = DIV_W / DIGIT_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam int M_TDATA_W = ((ORD_W + 2 * OUT_W + 7) / 8) * 8;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_EMIT0,
        DP_EMIT1,
        DP_MUL_XP,
        DP_RND_XP,
        DP_MUL_SLOPE,
        DP_NUM,
        DP_DIV_P,
        DP_DIFF,
        DP_MUL_VAL,
        DP_DIV_V,
        DP_EMITK
    } dp_op_t;

    typedef struct packed {
        dp_op_t         op;
        logic [K_W-1:0] k;
        logic           last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic div_busy;
        logic div_done;
    } dp_status_t;

    typedef logic [MAX_ORDER:0][SCALE_W-1:0] scale_tab_t;

    // sqrt((2k-1)/2) in q.26, floor of sqrt((2k-1) * 2^51)
    function automatic scale_tab_t scale_table_f();
        scale_tab_t  tab;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        tab = '0;
        for (int k = 1; k <= MAX_ORDER; k++) begin
            v = 64'(2 * k - 1) << 51;
            r = '0;
            b = 64'd1 << 62;
            for (int j = 0; j < 32; j++) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            tab[k] = SCALE_W'(r);
        end
        return tab;
    endfunction

    localparam scale_tab_t SCALE_TAB = scale_table_f();

endpackage

FILE: rtl/lobatto_shape_function_eval_top.sv
// channel   | dir | handshake          | payload
// s_        | in  | s_tvalid/s_tready  | s_tdata: sample_point q2.30
// m_        | out | m_tvalid/m_tready  | m_tdata: order, value, slope; m_tlast: last of run
// cfg_      | in  | cfg_wr_en          | cfg_wr_data: highest_order
//
// one input item gives top+1 result items (orders 0 to top); top is highest_order, or 1 when it is 0
// orders 0 and 1 need no division; every higher order takes two passes
// through the shared 8 bit per cycle divider
// a stalled m_ side holds the run at the next result; the next item is taken
// once the last result of a run sits in the output register
// aresetn is synchronous, active low; highest_order resets to 31
module lobatto_shape_function_eval_top import lsfe_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [HO_W-1:0]      cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [X_W-1:0]       s_tdata,   // sample_point
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // order_index, shape_value, shape_slope, zero pad
    output logic                 m_tlast
);

    localparam int M_PAD_W = M_TDATA_W - ORD_W - 2 * OUT_W;

    dp_cmd_t                 dp_cmd;
    dp_status_t              dp_status;
    logic [ORD_W-1:0]        m_order;
    logic signed [OUT_W-1:0] m_value;
    logic signed [OUT_W-1:0] m_slope;

    lsfe_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .cmd         (dp_cmd),
        .status      (dp_status)
    );

    lsfe_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (dp_cmd),
        .status   (dp_status),
        .s_sample ($signed(s_tdata)),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_order  (m_order),
        .m_value  (m_value),
        .m_slope  (m_slope),
        .m_last   (m_tlast)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, m_slope, m_value, m_order};

`ifndef SYNTHESIS
    a_ready_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !dp_status.div_busy)
        else $error("input ready while divider busy");

    a_order0_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[ORD_W-1:0] == '0) |-> !m_tlast)
        else $error("order zero marked last");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.op == DP_EMIT0 || dp_cmd.op == DP_EMIT1 || dp_cmd.op == DP_EMITK)
        |-> dp_status.out_free)
        else $error("result written over a waiting item");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.op == DP_DIV_P || dp_cmd.op == DP_DIV_V) |-> !dp_status.div_busy)
        else $error("divider started while busy");
`endif

endmodule

FILE: rtl/lsfe_div.sv
module lsfe_div import lsfe_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [ODD_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]   dvd_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [ODD_W-1:0]   dvs_reg;
    logic [ODD_W-1:0]   rem_reg;
    logic [ODD_W-1:0]   rem_next;
    logic [DIGIT_W-1:0] digit_next;
    logic [DCNT_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    // one quotient digit per cycle, msb first
    always_comb begin
        logic [ODD_W:0] trial;
        rem_next   = rem_reg;
        digit_next = '0;
        for (int i = 0; i < DIGIT_W; i++) begin
            trial = {rem_next, dvd_reg[DIV_W-1-i]};
            if (trial >= {1'b0, dvs_reg}) begin
                trial = trial - {1'b0, dvs_reg};
                digit_next[DIGIT_W-1-i] = 1'b1;
            end
            rem_next = trial[ODD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + DCNT_W'(1);
                if (cnt_reg == DCNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << DIGIT_W;
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_W-DIGIT_W-1:0], digit_next};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/lsfe_dp.sv
module lsfe_dp import lsfe_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dp_cmd_t                 cmd,
    output dp_status_t              status,
    input  logic signed [X_W-1:0]   s_sample,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ORD_W-1:0]        m_order,
    output logic signed [OUT_W-1:0] m_value,
    output logic signed [OUT_W-1:0] m_slope,
    output logic                    m_last
);

    localparam logic signed [X_W-1:0]    X_ONE      = X_W'(64'd1 << FRAC);
    localparam logic signed [X_W-1:0]    X_NEG      = -X_ONE;
    localparam logic signed [X_W:0]      X1_ONE     = (X_W+1)'(64'd1 << FRAC);
    localparam logic signed [P_W-1:0]    P_ONE      = P_W'(64'd1 << FRAC);
    // halving plus the q.30 to q.26 step
    localparam int                       LIN_SHIFT  = FRAC - OUT_FRAC + 1;
    localparam logic signed [X_W:0]      LIN_HALF   = (X_W+1)'(1) << (LIN_SHIFT - 1);
    localparam logic signed [OUT_W-1:0]  SLOPE_HALF = OUT_W'(1) << (OUT_FRAC - 1);
    localparam logic [PROD_W:0]          RND_HALF   = (PROD_W+1)'(1) << (FRAC - 1);
    localparam logic signed [PROD_W-1:0] SAT_HI     = (PROD_W'(1) << (OUT_W - 1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] SAT_LO     = -(PROD_W'(1) << (OUT_W - 1));

    function automatic logic signed [PROD_W-1:0] round_frac(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W:0] ve;
        logic [PROD_W:0]        mag;
        logic [PROD_W:0]        q;
        ve  = (PROD_W+1)'(v);
        mag = ve[PROD_W] ? -ve : ve;
        q   = (mag + RND_HALF) >> FRAC;
        return PROD_W'(ve[PROD_W] ? -q : q);
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] c;
        c = v;
        if (v > SAT_HI) c = SAT_HI;
        if (v < SAT_LO) c = SAT_LO;
        return OUT_W'(c);
    endfunction

    logic signed [X_W-1:0]    x_reg;
    logic signed [P_W-1:0]    p2_reg;
    logic signed [P_W-1:0]    p1_reg;
    logic signed [P_W-1:0]    xp_reg;
    logic signed [T_W-1:0]    t_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic signed [P_W-1:0]    pcur_reg;
    logic signed [MA_W-1:0]   diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [OUT_W-1:0]  slope_reg;
    logic                     num_neg_reg;
    logic                     val_neg_reg;

    logic                     out_valid_reg;
    logic [ORD_W-1:0]         out_order_reg;
    logic signed [OUT_W-1:0]  out_value_reg;
    logic signed [OUT_W-1:0]  out_slope_reg;
    logic                     out_last_reg;

    logic [ODD_W-1:0]         odd;
    logic [K_W-1:0]           km1;
    logic [SCALE_W-1:0]       scale;
    logic signed [X_W-1:0]    x_clamped;
    logic signed [X_W:0]      x_ext;
    logic signed [X_W:0]      lin_sum;
    logic signed [X_W:0]      lin_rnd;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [T_W-1:0]    t_next;
    logic signed [NUM_W-1:0]  t_ext;
    logic signed [NUM_W-1:0]  km1p2;
    logic signed [NUM_W-1:0]  num_next;
    logic [NUM_W-1:0]         num_mag;
    logic signed [PROD_W:0]   prod_ext;
    logic [PROD_W:0]          prod_mag;
    logic [PROD_W:0]          val_dvd;
    logic signed [P_W-1:0]    pcur_next;
    logic signed [MA_W-1:0]   diff_next;
    logic signed [PROD_W-1:0] val_wide;
    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic [ODD_W-1:0]         div_divisor;
    logic                     div_busy;
    logic                     div_done;
    logic [DIV_W-1:0]         div_q;
    logic                     out_free;

    assign odd   = {cmd.k, 1'b0} - ODD_W'(1);
    assign km1   = cmd.k - K_W'(1);
    assign scale = SCALE_TAB[cmd.k];

    always_comb begin
        x_clamped = s_sample;
        if (s_sample > X_ONE) x_clamped = X_ONE;
        if (s_sample < X_NEG) x_clamped = X_NEG;
    end

    // linear orders
    assign x_ext   = (X_W+1)'(x_reg);
    assign lin_sum = (cmd.op == DP_EMIT0) ? (X1_ONE - x_ext) : (X1_ONE + x_ext);
    assign lin_rnd = (lin_sum + LIN_HALF) >>> LIN_SHIFT;

    // shared multiplier
    assign mul_a     = (cmd.op == DP_MUL_VAL) ? diff_reg : MA_W'(p1_reg);
    assign mul_b     = (cmd.op == DP_MUL_XP) ? MB_W'(x_reg) : $signed({1'b0, scale});
    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // three-term recurrence numerator
    assign t_next   = T_W'($signed({1'b0, odd})) * T_W'(xp_reg);
    assign t_ext    = NUM_W'(t_reg);
    assign km1p2    = NUM_W'($signed({1'b0, km1})) * NUM_W'(p2_reg);
    assign num_next = t_ext - km1p2;
    assign num_mag  = num_reg[NUM_W-1] ? -num_reg : num_reg;

    assign prod_ext = (PROD_W+1)'(prod_reg);
    assign prod_mag = prod_ext[PROD_W] ? -prod_ext : prod_ext;
    assign val_dvd  = (prod_mag + ((PROD_W+1)'(odd) << (FRAC - 1))) >> FRAC;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = DIV_W'(num_mag) + DIV_W'(cmd.k >> 1);
        div_divisor  = ODD_W'(cmd.k);
        if (cmd.op == DP_DIV_P) begin
            div_start = 1'b1;
        end else if (cmd.op == DP_DIV_V) begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(val_dvd);
            div_divisor  = odd;
        end
    end

    lsfe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign pcur_next = num_neg_reg ? P_W'(-div_q) : P_W'(div_q);
    assign diff_next = MA_W'(pcur_next) - MA_W'(p2_reg);
    assign val_wide  = val_neg_reg ? -PROD_W'(div_q) : PROD_W'(div_q);

    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            DP_LOAD: begin
                x_reg  <= x_clamped;
                p2_reg <= P_ONE;
                p1_reg <= P_W'(x_clamped);
            end
            DP_EMIT0: begin
                out_order_reg <= '0;
                out_value_reg <= OUT_W'(lin_rnd);
                out_slope_reg <= -SLOPE_HALF;
                out_last_reg  <= 1'b0;
            end
            DP_EMIT1: begin
                out_order_reg <= ORD_W'(1);
                out_value_reg <= OUT_W'(lin_rnd);
                out_slope_reg <= SLOPE_HALF;
                out_last_reg  <= cmd.last;
            end
            DP_MUL_XP: begin
                prod_reg <= prod_next;
            end
            DP_RND_XP: begin
                xp_reg <= P_W'(round_frac(prod_reg));
            end
            DP_MUL_SLOPE: begin
                prod_reg <= prod_next;
                t_reg    <= t_next;
            end
            DP_NUM: begin
                num_reg   <= num_next;
                slope_reg <= sat_out(round_frac(prod_reg));
            end
            DP_DIV_P: begin
                num_neg_reg <= num_reg[NUM_W-1];
            end
            DP_DIFF: begin
                pcur_reg <= pcur_next;
                diff_reg <= diff_next;
            end
            DP_MUL_VAL: begin
                prod_reg <= prod_next;
            end
            DP_DIV_V: begin
                val_neg_reg <= prod_reg[PROD_W-1];
            end
            DP_EMITK: begin
                out_order_reg <= ORD_W'(cmd.k);
                out_value_reg <= sat_out(val_wide);
                out_slope_reg <= slope_reg;
                out_last_reg  <= cmd.last;
                p2_reg        <= p1_reg;
                p1_reg        <= pcur_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == DP_EMIT0 || cmd.op == DP_EMIT1 || cmd.op == DP_EMITK) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = out_free;
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;

    assign m_valid = out_valid_reg;
    assign m_order = out_order_reg;
    assign m_value = out_value_reg;
    assign m_slope = out_slope_reg;
    assign m_last  = out_last_reg;

endmodule

FILE: rtl/lsfe_ctrl.sv
module lsfe_ctrl import lsfe_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [HO_W-1:0] cfg_wr_data,
    input  logic            in_valid,
    output logic            in_ready,
    output dp_cmd_t         cmd,
    input  dp_status_t      status
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMIT0,
        ST_EMIT1,
        ST_MUL_XP,
        ST_RND_XP,
        ST_MUL_SLOPE,
        ST_NUM,
        ST_DIV_P,
        ST_WAIT_P,
        ST_DIFF,
        ST_MUL_VAL,
        ST_DIV_V,
        ST_WAIT_V,
        ST_EMITK
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [K_W-1:0]  k_reg;
    logic [K_W-1:0]  k_next;
    logic [HO_W-1:0] ho_reg;
    logic [K_W-1:0]  top;

    // order zero means one, clip at the top order
    always_comb begin
        if (ho_reg == '0) begin
            top = K_W'(1);
        end else if (32'(ho_reg) > MAX_ORDER) begin
            top = K_W'(MAX_ORDER);
        end else begin
            top = K_W'(ho_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd.op     = DP_NOP;
        cmd.k      = k_reg;
        cmd.last   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_EMIT0;
                end
            end
            ST_EMIT0: begin
                if (status.out_free) begin
                    cmd.op     = DP_EMIT0;
                    state_next = ST_EMIT1;
                end
            end
            ST_EMIT1: begin
                if (status.out_free) begin
                    cmd.op   = DP_EMIT1;
                    cmd.last = (top == K_W'(1));
                    if (top == K_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = K_W'(2);
                        state_next = ST_MUL_XP;
                    end
                end
            end
            ST_MUL_XP: begin
                cmd.op     = DP_MUL_XP;
                state_next = ST_RND_XP;
            end
            ST_RND_XP: begin
                cmd.op     = DP_RND_XP;
                state_next = ST_MUL_SLOPE;
            end
            ST_MUL_SLOPE: begin
                cmd.op     = DP_MUL_SLOPE;
                state_next = ST_NUM;
            end
            ST_NUM: begin
                cmd.op     = DP_NUM;
                state_next = ST_DIV_P;
            end
            ST_DIV_P: begin
                cmd.op     = DP_DIV_P;
                state_next = ST_WAIT_P;
            end
            ST_WAIT_P: begin
                if (status.div_done) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                cmd.op     = DP_DIFF;
                state_next = ST_MUL_VAL;
            end
            ST_MUL_VAL: begin
                cmd.op     = DP_MUL_VAL;
                state_next = ST_DIV_V;
            end
            ST_DIV_V: begin
                cmd.op     = DP_DIV_V;
                state_next = ST_WAIT_V;
            end
            ST_WAIT_V: begin
                if (status.div_done) begin
                    state_next = ST_EMITK;
                end
            end
            ST_EMITK: begin
                if (status.out_free) begin
                    cmd.op   = DP_EMITK;
                    cmd.last = (k_reg == top);
                    if (k_reg == top) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + K_W'(1);
                        state_next = ST_MUL_XP;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            ho_reg    <= HO_W'(31);
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (cfg_wr_en) begin
                ho_reg <= cfg_wr_data;
            end
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lsfe_pkg::*;

    localparam longint ONE_Q30   = 64'sd1 << 30;
    localparam int     HALF_Q26  = 1 << 25;
    localparam int     CYCLE_CAP = 1_000_000;
    localparam int     PHASES    = 14;
    localparam int     PER_PHASE = 20;
    localparam int     HOLD_AT   = 150;
    localparam int     HOLD_LEN  = 1500;
    localparam int     N_DIR     = 21;

    typedef struct packed {
        logic [ORD_W-1:0] order;
        logic [OUT_W-1:0] value;
        logic [OUT_W-1:0] slope;
        logic             last;
    } shape_res_t;

    typedef struct packed {
        logic [HO_W-1:0] ho;
        logic [X_W-1:0]  x;
        logic            typed;
        logic [OUT_W-1:0] v0;
        logic [OUT_W-1:0] v1;
    } point_row_t;

    // highest order, point, typed flag, order 0 value, order 1 value
    localparam point_row_t POINT_TAB [0:N_DIR-1] = '{
        '{5'd31, 32'h0000_0000, 1'b1, 32'd33554432, 32'd33554432},
        '{5'd31, 32'h4000_0000, 1'b1, 32'd0,        32'd67108864},
        '{5'd31, 32'hC000_0000, 1'b1, 32'd67108864, 32'd0},
        '{5'd31, 32'h7FFF_FFFF, 1'b1, 32'd0,        32'd67108864},
        '{5'd31, 32'h8000_0000, 1'b1, 32'd67108864, 32'd0},
        '{5'd31, 32'h4000_0001, 1'b1, 32'd0,        32'd67108864},
        '{5'd31, 32'hBFFF_FFFF, 1'b1, 32'd67108864, 32'd0},
        '{5'd31, 32'h0000_0001, 1'b0, 32'd0,        32'd0},
        '{5'd31, 32'hFFFF_FFFF, 1'b0, 32'd0,        32'd0},
        '{5'd31, 32'h2000_0000, 1'b1, 32'd16777216, 32'd50331648},
        '{5'd31, 32'hE000_0000, 1'b1, 32'd50331648, 32'd16777216},
        '{5'd31, 32'h1555_5555, 1'b0, 32'd0,        32'd0},
        '{5'd0,  32'h1234_5678, 1'b0, 32'd0,        32'd0},
        '{5'd0,  32'h9ABC_DEF0, 1'b1, 32'd67108864, 32'd0},
        '{5'd1,  32'hE000_0000, 1'b1, 32'd50331648, 32'd16777216},
        '{5'd1,  32'h3FFF_FFFF, 1'b0, 32'd0,        32'd0},
        '{5'd2,  32'h2AAA_AAAA, 1'b0, 32'd0,        32'd0},
        '{5'd2,  32'hD555_5556, 1'b0, 32'd0,        32'd0},
        '{5'd30, 32'h3FFF_FFFF, 1'b0, 32'd0,        32'd0},
        '{5'd30, 32'hC000_0001, 1'b0, 32'd0,        32'd0},
        '{5'd17, 32'h0000_ABCD, 1'b0, 32'd0,        32'd0}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [HO_W-1:0]      cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [X_W-1:0]       s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    shape_res_t      due_shapes [$];
    logic [HO_W-1:0] cur_order = 5'd31;
    int              err_cnt   = 0;
    int              cycle_cnt = 0;
    int              sent_cnt  = 0;

    lobatto_shape_function_eval_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // divide rounding to nearest, halves away from zero
    function automatic longint div_round(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint isqrt_floor(longint v);
        longint r;
        longint t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'sd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[OUT_W-1:0];
    endfunction

    function automatic void add_shape(int k, longint val, longint slp, bit last);
        shape_res_t r;
        r.order = k[ORD_W-1:0];
        r.value = clamp32(val);
        r.slope = clamp32(slp);
        r.last  = last;
        due_shapes.push_back(r);
    endfunction

    function automatic void predict_lobatto_run(logic [X_W-1:0] raw, logic [HO_W-1:0] ho);
        longint x;
        longint p_km2;
        longint p_km1;
        longint p_k;
        longint odd;
        longint xp;
        longint sc;
        int     top;
        x = longint'($signed(raw));
        if (x > ONE_Q30) x = ONE_Q30;
        if (x < -ONE_Q30) x = -ONE_Q30;
        top = (ho == 0) ? 1 : int'(ho);
        if (top > MAX_ORDER) top = MAX_ORDER;
        add_shape(0, div_round(ONE_Q30 - x, 32), -HALF_Q26, 1'b0);
        add_shape(1, div_round(ONE_Q30 + x, 32), HALF_Q26, top == 1);
        p_km2 = ONE_Q30;
        p_km1 = x;
        for (int k = 2; k <= top; k++) begin
            odd = 2 * k - 1;
            xp  = div_round(x * p_km1, ONE_Q30);
            sc  = isqrt_floor(odd <<< 51);
            p_k = div_round(odd * xp - (k - 1) * p_km2, k);
            add_shape(k, div_round((p_k - p_km2) * sc, odd * ONE_Q30),
                      div_round(p_km1 * sc, ONE_Q30), k == top);
            p_km2 = p_km1;
            p_km1 = p_k;
        end
    endfunction

    function automatic int draw_wait(int n);
        if (n % 50 < 12) return 0;
        return $urandom_range(0, 5);
    endfunction

    task automatic drain_results();
        while (due_shapes.size() != 0) @(posedge aclk);
    endtask

    task automatic set_order(logic [HO_W-1:0] ho);
        s_tvalid <= 1'b0;
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ho;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_order = ho;
    endtask

    task automatic send_point(logic [X_W-1:0] x, logic typed,
                              logic [OUT_W-1:0] v0, logic [OUT_W-1:0] v1);
        int gap;
        int base;
        gap = draw_wait(sent_cnt);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge aclk); while (!s_tready);
        base = due_shapes.size();
        predict_lobatto_run(x, cur_order);
        if (typed) begin
            due_shapes[base].value     = v0;
            due_shapes[base + 1].value = v1;
        end
        sent_cnt++;
    endtask

    initial begin
        logic [HO_W-1:0] ho;
        logic [X_W-1:0]  xr;
        int              pick;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIR; i++) begin
            if (POINT_TAB[i].ho != cur_order) set_order(POINT_TAB[i].ho);
            send_point(POINT_TAB[i].x, POINT_TAB[i].typed, POINT_TAB[i].v0, POINT_TAB[i].v1);
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) ho = 5'd1;
            else if (p == 1) ho = 5'd31;
            else if (p == 2) ho = 5'd0;
            else if (p % 4 == 3) ho = HO_W'($urandom_range(7, 31));
            else ho = HO_W'($urandom_range(0, 6));
            set_order(ho);
            for (int i = 0; i < PER_PHASE; i++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    xr = $urandom;
                end else if (pick == 1) begin
                    case ($urandom_range(0, 4))
                        0: xr = 32'h4000_0000;
                        1: xr = 32'hC000_0000;
                        2: xr = 32'h0000_0000;
                        3: xr = 32'h3FFF_FFFF;
                        default: xr = 32'hC000_0001;
                    endcase
                end else begin
                    xr = $urandom_range(0, 32'h8000_0000);
                    xr = xr - 32'h4000_0000;
                end
                send_point(xr, 1'b0, '0, '0);
            end
        end

        s_tvalid <= 1'b0;
        drain_results();
        repeat (50) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        shape_res_t      want;
        logic [OUT_W-1:0] got_val;
        logic [OUT_W-1:0] got_slp;
        logic [ORD_W-1:0] got_ord;
        int              stall;
        int              rx_cnt;
        rx_cnt = 0;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            // long hold-off once, so the block backs up onto its input
            stall = (rx_cnt == HOLD_AT) ? HOLD_LEN : draw_wait(rx_cnt + 25);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            rx_cnt++;
            got_ord = m_tdata[ORD_W-1:0];
            got_val = m_tdata[ORD_W +: OUT_W];
            got_slp = m_tdata[ORD_W + OUT_W +: OUT_W];
            if (due_shapes.size() == 0) begin
                $error("unexpected item: order %0d value %0d", got_ord, $signed(got_val));
                err_cnt++;
            end else begin
                want = due_shapes.pop_front();
                if (got_ord !== want.order) begin
                    $error("order_index mismatch: expected %0d, got %0d", want.order, got_ord);
                    err_cnt++;
                end
                if (got_val !== want.value) begin
                    $error("shape_value mismatch: expected %0d, got %0d",
                           $signed(want.value), $signed(got_val));
                    err_cnt++;
                end
                if (got_slp !== want.slope) begin
                    $error("shape_slope mismatch: expected %0d, got %0d",
                           $signed(want.slope), $signed(got_slp));
                    err_cnt++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_of_run mismatch: expected %0d, got %0d", want.last, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

endmodule
